@@ hdl/flc_pkg.sv @@
// ----------------------------------------------------------------------------
// flc_pkg
// Shared sizes, codes and controller/datapath interface types for the
// lock coordinator.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_CLIENTS = 16;

    localparam int ID_W       = 22;
    localparam int COUNT_W    = 32;
    localparam int NCLI_W     = 5;
    localparam int ACTION_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int LEVEL_W    = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam int QP_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int USED_W = $clog2(MAX_CLIENTS + 1);
    localparam int LIM_W  = (USED_W > NCLI_W) ? USED_W : NCLI_W;

    localparam logic [NCLI_W-1:0] NUM_CLIENTS_RESET = NCLI_W'(16);

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_GRANT   = 2'd2,
        ACT_OTHER   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_QUEUED   = 3'd0,
        ST_GRANTED  = 3'd1,
        ST_HANDOFF  = 3'd2,
        ST_FREED    = 3'd3,
        ST_FULL     = 3'd4,
        ST_REJECTED = 3'd5,
        ST_UNKNOWN  = 3'd6
    } status_code_t;

    typedef struct packed {
        logic         latch_in;
        logic         q_push;
        logic         q_pop;
        logic         lock_set;
        logic         lock_clr;
        logic         gid_from_in;
        logic         gid_from_q;
        logic         lookup;
        logic         count;
        logic         emit;
        status_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    lock_busy;
        logic    q_empty;
        logic    q_full;
    } dp_stat_t;

endpackage

@@ hdl/flc_ctrl.sv @@
// ----------------------------------------------------------------------------
// flc_ctrl
// Sequencer: decodes each transaction and steps the datapath through
// queue access, slot lookup, counter update and result issue.
// ----------------------------------------------------------------------------
module flc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  flc_pkg::dp_stat_t stat,
    output flc_pkg::dp_cmd_t  cmd
);
    import flc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOADQ,
        S_LOOKUP,
        S_COUNT,
        S_RESULT
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    status_code_t code_reg;
    status_code_t code_next;

    always_comb
    begin
        state_next      = state_reg;
        code_next       = code_reg;
        cmd             = '0;
        cmd.code        = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESULT;
                case (stat.action)
                    ACT_REQUEST:
                    begin
                        if (!stat.lock_busy)
                        begin
                            cmd.lock_set    = 1'b1;
                            cmd.gid_from_in = 1'b1;
                            code_next       = ST_GRANTED;
                            state_next      = S_LOOKUP;
                        end
                        else if (!stat.q_full)
                        begin
                            cmd.q_push = 1'b1;
                            code_next  = ST_QUEUED;
                        end
                        else
                        begin
                            code_next = ST_FULL;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (!stat.q_empty)
                        begin
                            cmd.q_pop    = 1'b1;
                            cmd.lock_set = 1'b1;
                            code_next    = ST_HANDOFF;
                            state_next   = S_LOADQ;
                        end
                        else
                        begin
                            cmd.lock_clr = 1'b1;
                            code_next    = ST_FREED;
                        end
                    end
                    ACT_GRANT: code_next = ST_REJECTED;
                    default:   code_next = ST_UNKNOWN;
                endcase
            end
            S_LOADQ:
            begin
                cmd.gid_from_q = 1'b1;
                state_next     = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_QUEUED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hdl/flc_datapath.sv @@
// ----------------------------------------------------------------------------
// flc_datapath
// Lock flag, wait FIFO, client slot table, per-slot grant counters and the
// result register.
// ----------------------------------------------------------------------------
module flc_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  flc_pkg::dp_cmd_t              cmd,
    output flc_pkg::dp_stat_t             stat,
    input  logic [flc_pkg::ACTION_W-1:0]  action,
    input  logic [flc_pkg::ID_W-1:0]      requester_id,
    input  logic [flc_pkg::NCLI_W-1:0]    num_clients,
    output logic                          done,
    output logic [2:0]                    status,
    output logic                          grant_valid,
    output logic [flc_pkg::ID_W-1:0]      granted_id,
    output logic [flc_pkg::SLOT_OUT_W-1:0] granted_slot,
    output logic [flc_pkg::COUNT_W-1:0]   granted_count,
    output logic                          slot_overflow,
    output logic [flc_pkg::LEVEL_W-1:0]   queue_level
);
    import flc_pkg::*;

    localparam logic [QP_W:0] QD_EXT = (QP_W + 1)'(QUEUE_DEPTH);

    action_t             action_reg;
    logic [ID_W-1:0]     id_reg;
    logic                lock_busy_reg;
    logic [QP_W-1:0]     head_reg;
    logic [QC_W-1:0]     count_reg;
    logic [ID_W-1:0]     q_rdata_reg;
    logic [ID_W-1:0]     gid_reg;
    logic                grant_reg;
    logic [USED_W-1:0]   used_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                found_reg;
    logic [COUNT_W-1:0]  cnt_val_reg;

    logic [ID_W-1:0]     queue_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]     owner_reg [MAX_CLIENTS];
    logic [COUNT_W-1:0]  counter_reg [MAX_CLIENTS];

    logic                done_reg;
    status_code_t        status_reg;
    logic                grant_valid_reg;
    logic [ID_W-1:0]     granted_id_reg;
    logic [SLOT_OUT_W-1:0] granted_slot_reg;
    logic [COUNT_W-1:0]  granted_count_reg;
    logic                overflow_reg;
    logic [LEVEL_W-1:0]  level_reg;

    logic [QP_W:0]       tail_sum;
    logic [QP_W-1:0]     tail;
    logic [QP_W-1:0]     head_next;
    logic                q_full;
    logic                q_empty;
    logic [MAX_CLIENTS-1:0] match;
    logic [SLOT_W-1:0]   hit_slot;
    logic                hit;
    logic [LIM_W-1:0]    limit;
    logic                can_alloc;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [31:0]         slot_wide;
    logic [31:0]         level_wide;

    // FIFO pointers
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (QP_W + 1)'(count_reg);
        if (tail_sum >= QD_EXT)
            tail_sum = tail_sum - QD_EXT;
        tail      = tail_sum[QP_W-1:0];
        head_next = (head_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        q_full    = (count_reg == QC_W'(QUEUE_DEPTH));
        q_empty   = (count_reg == '0);
    end

    // slot table search; owners of used slots are unique
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            match[i] = (USED_W'(i) < used_reg) && (owner_reg[i] == gid_reg);
            hit_slot = hit_slot | (match[i] ? SLOT_W'(i) : '0);
        end
        hit = |match;
        limit = (LIM_W'(num_clients) > LIM_W'(MAX_CLIENTS)) ?
                LIM_W'(MAX_CLIENTS) : LIM_W'(num_clients);
        can_alloc = (LIM_W'(used_reg) < limit);
        cnt_inc = counter_reg[slot_reg] + 1'b1;
        slot_wide = 32'(slot_reg);
        level_wide = 32'(count_reg);
    end

    assign stat.action    = action_reg;
    assign stat.lock_busy = lock_busy_reg;
    assign stat.q_empty   = q_empty;
    assign stat.q_full    = q_full;

    always_ff @(posedge clk)
    begin
        if (cmd.q_push)
            queue_mem[tail] <= id_reg;
        if (cmd.q_pop)
            q_rdata_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && !hit && can_alloc)
            owner_reg[SLOT_W'(used_reg)] <= gid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_busy_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            grant_reg     <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < MAX_CLIENTS; i++)
                counter_reg[i] <= '0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.lock_set)
                lock_busy_reg <= 1'b1;
            else if (cmd.lock_clr)
                lock_busy_reg <= 1'b0;
            if (cmd.q_push)
                count_reg <= count_reg + 1'b1;
            else if (cmd.q_pop)
            begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_next;
            end
            if (cmd.latch_in)
                grant_reg <= 1'b0;
            else if (cmd.gid_from_in || cmd.gid_from_q)
                grant_reg <= 1'b1;
            if (cmd.lookup)
            begin
                found_reg <= hit || can_alloc;
                if (!hit && can_alloc)
                    used_reg <= used_reg + 1'b1;
            end
            if (cmd.count && found_reg)
                counter_reg[slot_reg] <= cnt_inc;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg <= action_t'(action);
            id_reg     <= requester_id;
        end
        if (cmd.gid_from_in)
            gid_reg <= id_reg;
        else if (cmd.gid_from_q)
            gid_reg <= q_rdata_reg;
        if (cmd.lookup)
            slot_reg <= hit ? hit_slot : (can_alloc ? SLOT_W'(used_reg) : '0);
        if (cmd.count)
            cnt_val_reg <= found_reg ? cnt_inc : '0;
        if (cmd.emit)
        begin
            status_reg        <= cmd.code;
            grant_valid_reg   <= grant_reg;
            granted_id_reg    <= grant_reg ? gid_reg : '0;
            granted_slot_reg  <= (grant_reg && found_reg) ? slot_wide[SLOT_OUT_W-1:0] : '0;
            granted_count_reg <= grant_reg ? cnt_val_reg : '0;
            overflow_reg      <= grant_reg && !found_reg;
            level_reg         <= level_wide[LEVEL_W-1:0];
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign grant_valid   = grant_valid_reg;
    assign granted_id    = granted_id_reg;
    assign granted_slot  = granted_slot_reg;
    assign granted_count = granted_count_reg;
    assign slot_overflow = overflow_reg;
    assign queue_level   = level_reg;

endmodule

@@ hdl/fifo_lock_coordinator.sv @@
// ----------------------------------------------------------------------------
// fifo_lock_coordinator
// Central lock coordinator with a FIFO of waiting requesters and per-client
// grant counters.
//
// A transaction is taken when start is high and busy is low; action and
// requester_id are sampled then. Exactly one result follows: done is high
// for one cycle with status, grant fields and queue_level valid. The
// receiver cannot stall, so results are never held back.
// The controller walks decode, FIFO read, slot lookup and counter update,
// so the next transaction can be taken once it is back in idle. With no
// grant it goes from decode to the result; a request granted at once adds
// slot lookup and counter update, a handoff release also the FIFO read. done
// rises in the cycle in which the next start may be taken. num_clients sits
// at byte address 0 on the APB port (reset value 16) and is to be written
// only while idle, which the block does not enforce. pready is always high.
// Reset frees the lock, empties the FIFO, clears all slots and counters.
// ----------------------------------------------------------------------------
module fifo_lock_coordinator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [flc_pkg::PADDR_W-1:0]    paddr,
    input  logic [flc_pkg::PDATA_W-1:0]    pwdata,
    output logic [flc_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [flc_pkg::ACTION_W-1:0]   action,
    input  logic [flc_pkg::ID_W-1:0]       requester_id,
    output logic                           done,
    output logic [2:0]                     status,
    output logic                           grant_valid,
    output logic [flc_pkg::ID_W-1:0]       granted_id,
    output logic [flc_pkg::SLOT_OUT_W-1:0] granted_slot,
    output logic [flc_pkg::COUNT_W-1:0]    granted_count,
    output logic                           slot_overflow,
    output logic [flc_pkg::LEVEL_W-1:0]    queue_level
);
    import flc_pkg::*;

    localparam logic REG_NUM_CLIENTS = 1'b0;

    logic [NCLI_W-1:0] num_clients_reg;
    logic              cfg_write;
    dp_cmd_t           cmd;
    dp_stat_t          dp_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1] == REG_NUM_CLIENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_clients_reg <= NUM_CLIENTS_RESET;
        else if (cfg_write)
            num_clients_reg <= pwdata[NCLI_W-1:0];
    end

    assign prdata = (paddr[PADDR_W-1] == REG_NUM_CLIENTS) ?
                    PDATA_W'(num_clients_reg) : '0;

    flc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (dp_stat),
        .cmd   (cmd)
    );

    flc_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (dp_stat),
        .action        (action),
        .requester_id  (requester_id),
        .num_clients   (num_clients_reg),
        .done          (done),
        .status        (status),
        .grant_valid   (grant_valid),
        .granted_id    (granted_id),
        .granted_slot  (granted_slot),
        .granted_count (granted_count),
        .slot_overflow (slot_overflow),
        .queue_level   (queue_level)
    );

endmodule
